@@ src/scrp_pkg.sv @@
// ----------------------------------------------------------------------------
// scrp_pkg
// Shared types and constants of the serial command radio packetizer.
// ----------------------------------------------------------------------------
package scrp_pkg;

  localparam int PAYLOAD_BYTES = 32;
  localparam int FILL_W        = $clog2(PAYLOAD_BYTES + 1);
  localparam int QUEUE_DEPTH   = 4;
  localparam int CFG_IDX_W     = 8;
  localparam int MAX_RESULTS   = 3;

  localparam logic OP_SERIAL = 1'b0;
  localparam logic OP_STATUS = 1'b1;

  localparam logic DEST_SERIAL = 1'b0;
  localparam logic DEST_RADIO  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TRANSMIT_CODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_CODE     = 8'd1;

  localparam logic [7:0] REPLY_LEN = 8'd1;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_SIZE = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // One group of results produced by a single input item, first byte in slot 0.
  typedef struct packed {
    logic [1:0]                   cnt;
    logic                         dest;
    logic                         pend_end;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
  } scrp_job_t;

endpackage

@@ src/scrp_in_if.sv @@
// ----------------------------------------------------------------------------
// scrp_in_if
// Input channel: serial bytes and radio status items.
// ----------------------------------------------------------------------------
interface scrp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;
  logic       radio_ok;

  modport source (output valid, output opcode, output data_byte, output radio_ok,
                  input ready);
  modport sink   (input valid, input opcode, input data_byte, input radio_ok,
                  output ready);
endinterface

@@ src/scrp_out_if.sv @@
// ----------------------------------------------------------------------------
// scrp_out_if
// Result channel: bytes toward the serial port or the radio.
// ----------------------------------------------------------------------------
interface scrp_out_if;
  logic       valid;
  logic       ready;
  logic       destination;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       last;

  modport source (output valid, output destination, output out_byte,
                  output packet_end, output last, input ready);
  modport sink   (input valid, input destination, input out_byte,
                  input packet_end, input last, output ready);
endinterface

@@ src/scrp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// scrp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface scrp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/scrp_front.sv @@
// ----------------------------------------------------------------------------
// scrp_front
// Accepts input items, tracks command framing and packet state, and turns
// each item into a group of up to three result bytes.
// ----------------------------------------------------------------------------
module scrp_front
  import scrp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  scrp_in_if.sink          in_ch,
  scrp_cfg_if.sink         cfg_ch,
  input  logic             q_full,
  output logic             push,
  output scrp_job_t        push_job
);

  phase_t            phase_r, phase_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        seen_r, seen_nxt;
  logic [7:0]        pnum_r, pnum_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              link_r, link_nxt;
  logic              await_r, await_nxt;
  logic              fpend_r, fpend_nxt;
  logic [7:0]        tx_code_r;
  logic [7:0]        echo_code_r;

  logic              acc;
  logic              is_tx;
  logic [7:0]        seen_inc;
  logic              last_b;
  logic [FILL_W-1:0] fill_base;
  logic [FILL_W-1:0] fill_inc;
  logic              close;
  scrp_job_t         job;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign acc          = in_ch.valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_code_r   <= 8'd0;
      echo_code_r <= 8'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_TRANSMIT_CODE: tx_code_r   <= cfg_ch.data;
        REG_ECHO_CODE:     echo_code_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    pnum_nxt  = pnum_r;
    fill_nxt  = fill_r;
    link_nxt  = link_r;
    await_nxt = await_r;
    fpend_nxt = fpend_r;
    job       = '0;
    is_tx     = (cmd_r == tx_code_r);
    seen_inc  = seen_r + 8'd1;
    last_b    = (seen_inc == len_r);
    fill_base = fill_r;
    fill_inc  = fill_r + 1'b1;
    close     = 1'b0;
    if (acc) begin
      if (in_ch.opcode == OP_STATUS) begin
        if (await_r) begin
          await_nxt = 1'b0;
          link_nxt  = in_ch.radio_ok;
          if (fpend_r) begin
            fpend_nxt    = 1'b0;
            job.cnt      = 2'd3;
            job.dest     = DEST_SERIAL;
            job.bytes[0] = cmd_r;
            job.bytes[1] = REPLY_LEN;
            job.bytes[2] = {7'd0, in_ch.radio_ok};
          end
        end
      end else if (!await_r) begin
        unique case (phase_r)
          PH_DATA: begin
            seen_nxt = seen_inc;
            if (is_tx) begin
              if (link_r) begin
                job.dest = DEST_RADIO;
                if (fill_r == '0) begin
                  pnum_nxt     = pnum_r + 8'd1;
                  job.bytes[0] = pnum_r;
                  if (pnum_r == 8'd0) begin
                    job.cnt      = 2'd3;
                    job.bytes[1] = len_r;
                    job.bytes[2] = in_ch.data_byte;
                    fill_base    = FILL_W'(2);
                  end else begin
                    job.cnt      = 2'd2;
                    job.bytes[1] = in_ch.data_byte;
                    fill_base    = FILL_W'(1);
                  end
                end else begin
                  job.cnt      = 2'd1;
                  job.bytes[0] = in_ch.data_byte;
                end
                fill_inc = fill_base + 1'b1;
                if (len_r <= 8'(PAYLOAD_BYTES - 2)) begin
                  close = last_b;
                end else begin
                  close = (fill_inc == FILL_W'(PAYLOAD_BYTES)) || last_b;
                end
                job.pend_end = close;
                if (close) begin
                  fill_nxt  = '0;
                  await_nxt = 1'b1;
                end else begin
                  fill_nxt = fill_inc;
                end
              end
            end else if (cmd_r == echo_code_r) begin
              job.dest = DEST_SERIAL;
              if (seen_r == 8'd0) begin
                job.cnt      = 2'd3;
                job.bytes[0] = cmd_r;
                job.bytes[1] = len_r;
                job.bytes[2] = in_ch.data_byte;
              end else begin
                job.cnt      = 2'd1;
                job.bytes[0] = in_ch.data_byte;
              end
            end
            if (last_b) begin
              phase_nxt = PH_TYPE;
              if (is_tx) begin
                if (close) begin
                  fpend_nxt = 1'b1;
                end else begin
                  job.cnt      = 2'd3;
                  job.dest     = DEST_SERIAL;
                  job.pend_end = 1'b0;
                  job.bytes[0] = cmd_r;
                  job.bytes[1] = REPLY_LEN;
                  job.bytes[2] = {7'd0, link_r};
                end
              end
            end
          end
          PH_SIZE: begin
            len_nxt   = in_ch.data_byte;
            phase_nxt = (in_ch.data_byte == 8'd0) ? PH_TYPE : PH_DATA;
            seen_nxt  = 8'd0;
            pnum_nxt  = 8'd0;
            fill_nxt  = '0;
            link_nxt  = 1'b1;
          end
          default: begin
            cmd_nxt   = in_ch.data_byte;
            phase_nxt = PH_SIZE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      cmd_r   <= 8'd0;
      len_r   <= 8'd0;
      seen_r  <= 8'd0;
      pnum_r  <= 8'd0;
      fill_r  <= '0;
      link_r  <= 1'b1;
      await_r <= 1'b0;
      fpend_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      pnum_r  <= pnum_nxt;
      fill_r  <= fill_nxt;
      link_r  <= link_nxt;
      await_r <= await_nxt;
      fpend_r <= fpend_nxt;
    end
  end

  assign push     = acc && (job.cnt != 2'd0);
  assign push_job = job;

  a_pend_needs_await: assert property (@(posedge clk) disable iff (!rst_n)
    fpend_r |-> await_r) else $error("reply pending without status wait");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < FILL_W'(PAYLOAD_BYTES)) else $error("packet fill out of range");

  a_no_radio_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_job.dest == DEST_RADIO) |-> (!await_r && link_r))
    else $error("radio byte while link down or waiting");

endmodule

@@ src/scrp_queue.sv @@
// ----------------------------------------------------------------------------
// scrp_queue
// Short queue of result groups between the front and back parts.
// ----------------------------------------------------------------------------
module scrp_queue
  import scrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  scrp_job_t push_job,
  input  logic      pop,
  output scrp_job_t pop_job,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  scrp_job_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop)) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

@@ src/scrp_back.sv @@
// ----------------------------------------------------------------------------
// scrp_back
// Takes result groups from the queue and sends them one byte per cycle while out_ch is ready.
// ----------------------------------------------------------------------------
module scrp_back
  import scrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  scrp_job_t q_job,
  output logic      pop,
  scrp_out_if.source out_ch
);

  scrp_job_t  job_r;
  logic [1:0] idx_r;
  logic       busy_r;
  logic       at_last;
  logic       done;

  assign at_last = (idx_r == (job_r.cnt - 2'd1));
  assign done    = busy_r && out_ch.ready && at_last;
  assign pop     = (!busy_r || done) && !q_empty;

  assign out_ch.valid       = busy_r;
  assign out_ch.destination = job_r.dest;
  assign out_ch.out_byte    = job_r.bytes[idx_r];
  assign out_ch.last        = at_last;
  assign out_ch.packet_end  = at_last && job_r.pend_end;

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r && out_ch.ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < job_r.cnt)) else $error("result index past group");

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (q_job.cnt != 2'd0)) else $error("empty group in queue");

  a_end_on_radio: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_ch.packet_end) |-> (job_r.dest == DEST_RADIO))
    else $error("packet end on serial byte");

endmodule

@@ src/serial_command_radio_packetizer.sv @@
// ----------------------------------------------------------------------------
// serial_command_radio_packetizer
// Splits framed serial commands into radio packets, echoes, and replies.
//
//   channel | dir | handshake   | payload
//   in_ch   | in  | valid/ready | opcode, data_byte, radio_ok
//   out_ch  | out | valid/ready | destination, out_byte, packet_end, last
//   cfg_ch  | in  | valid/ready | index, data (0 transmit_code, 1 echo_code)
//
// An input item is taken whenever the four-entry group queue has room;
// each item yields 0 to 3 result bytes, which the back end sends on out_ch
// one byte per cycle while out_ch is ready.
// Reset is synchronous; cfg_ch is always ready.
// Stalls on out_ch back up into the queue before in_ch ready drops.
// ----------------------------------------------------------------------------
module serial_command_radio_packetizer
  import scrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  scrp_in_if.sink    in_ch,
  scrp_cfg_if.sink   cfg_ch,
  scrp_out_if.source out_ch
);

  logic      push;
  scrp_job_t push_job;
  logic      pop;
  scrp_job_t pop_job;
  logic      q_full;
  logic      q_empty;

  scrp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  scrp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  scrp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (pop_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

@@ verif/scrp_checker.sv @@
// ----------------------------------------------------------------------------
// scrp_checker
// Watches the configuration, input and result channels of the packetizer.
// Keeps its own copy of the framing state and the type codes, works out the
// radio and serial bytes that each accepted item causes, and compares every
// accepted result, field by field, with the oldest expected byte.
// ----------------------------------------------------------------------------
module scrp_checker
  import scrp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  scrp_in_if   in_ch,
  scrp_cfg_if  cfg_ch,
  scrp_out_if  out_ch,
  output int   errors,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       dest;
    logic [7:0] data;
    logic       pkt_end;
    logic       last;
  } emission_t;

  emission_t  due_bytes[$];
  emission_t  batch[$];

  logic [7:0] tx_code;
  logic [7:0] echo_code;
  phase_t     phase;
  logic [7:0] cmd_type;
  logic [7:0] pay_len;
  logic [7:0] seen;
  logic [7:0] pkt_num;
  logic [5:0] fill;
  logic       link_ok;
  logic       await_status;
  logic       final_pend;

  task automatic emit(input logic d, input logic [7:0] b, input logic pe);
    batch.push_back('{dest: d, data: b, pkt_end: pe, last: 1'b0});
  endtask

  task automatic emit_reply();
    emit(DEST_SERIAL, cmd_type, 1'b0);
    emit(DEST_SERIAL, REPLY_LEN, 1'b0);
    emit(DEST_SERIAL, {7'd0, link_ok}, 1'b0);
  endtask

  task automatic radio_byte(input logic [7:0] ch);
    logic close;
    if (!link_ok) begin
      seen = seen + 8'd1;
      return;
    end
    if (fill == 6'd0) begin
      emit(DEST_RADIO, pkt_num, 1'b0);
      fill = 6'd1;
      if (pkt_num == 8'd0) begin
        emit(DEST_RADIO, pay_len, 1'b0);
        fill = 6'd2;
      end
      pkt_num = pkt_num + 8'd1;
    end
    fill = fill + 6'd1;
    seen = seen + 8'd1;
    if (pay_len <= PAYLOAD_BYTES - 2)
      close = (seen == pay_len);
    else
      close = (fill == PAYLOAD_BYTES) || (seen == pay_len);
    emit(DEST_RADIO, ch, close);
    if (close) begin
      fill = 6'd0;
      await_status = 1'b1;
    end
  endtask

  task automatic packetize_item(input logic op, input logic [7:0] ch, input logic ok);
    logic      is_tx;
    emission_t e;
    batch.delete();
    if (op == OP_STATUS) begin
      if (await_status) begin
        await_status = 1'b0;
        link_ok = ok;
        if (final_pend) begin
          final_pend = 1'b0;
          emit_reply();
        end
      end
    end else if (!await_status) begin
      case (phase)
        PH_DATA: begin
          is_tx = (cmd_type == tx_code);
          if (is_tx) begin
            radio_byte(ch);
          end else if (cmd_type == echo_code) begin
            if (seen == 8'd0) begin
              emit(DEST_SERIAL, cmd_type, 1'b0);
              emit(DEST_SERIAL, pay_len, 1'b0);
            end
            emit(DEST_SERIAL, ch, 1'b0);
            seen = seen + 8'd1;
          end else begin
            seen = seen + 8'd1;
          end
          if (seen == pay_len) begin
            phase = PH_TYPE;
            if (is_tx) begin
              if (await_status)
                final_pend = 1'b1;
              else
                emit_reply();
            end
          end
        end
        PH_SIZE: begin
          pay_len = ch;
          phase   = (ch == 8'd0) ? PH_TYPE : PH_DATA;
          seen    = 8'd0;
          pkt_num = 8'd0;
          fill    = 6'd0;
          link_ok = 1'b1;
        end
        default: begin
          cmd_type = ch;
          phase    = PH_SIZE;
        end
      endcase
    end
    if (batch.size() != 0) begin
      e = batch.pop_back();
      e.last = 1'b1;
      batch.push_back(e);
    end
    foreach (batch[i]) due_bytes.push_back(batch[i]);
  endtask

  task automatic check_result();
    emission_t e;
    if (due_bytes.size() == 0) begin
      $error("unexpected result: destination %0d out_byte 0x%02h packet_end %0d last %0d",
             out_ch.destination, out_ch.out_byte, out_ch.packet_end, out_ch.last);
      errors++;
      return;
    end
    e = due_bytes.pop_front();
    if (out_ch.destination !== e.dest) begin
      $error("destination: expected %0d, actual %0d", e.dest, out_ch.destination);
      errors++;
    end
    if (out_ch.out_byte !== e.data) begin
      $error("out_byte: expected 0x%02h, actual 0x%02h", e.data, out_ch.out_byte);
      errors++;
    end
    if (out_ch.packet_end !== e.pkt_end) begin
      $error("packet_end: expected %0d, actual %0d", e.pkt_end, out_ch.packet_end);
      errors++;
    end
    if (out_ch.last !== e.last) begin
      $error("last: expected %0d, actual %0d", e.last, out_ch.last);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      errors       = 0;
      tx_code      = 8'd0;
      echo_code    = 8'd1;
      phase        = PH_TYPE;
      cmd_type     = 8'd0;
      pay_len      = 8'd0;
      seen         = 8'd0;
      pkt_num      = 8'd0;
      fill         = 6'd0;
      link_ok      = 1'b1;
      await_status = 1'b0;
      final_pend   = 1'b0;
      due_bytes.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        packetize_item(in_ch.opcode, in_ch.data_byte, in_ch.radio_ok);
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_TRANSMIT_CODE: tx_code = cfg_ch.data;
          REG_ECHO_CODE:     echo_code = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready)
        check_result();
    end
    outstanding <= due_bytes.size();
  end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives framed serial commands into the packetizer: transmit commands with
// radio status answers, echo and foreign commands, zero lengths, failing
// links and ignored items, under several type code settings. Random gaps on
// the input and random stalls on the result side; the checker compares.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import scrp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        quiet;
  logic [7:0]  tx_code;
  logic [7:0]  echo_code;
  int unsigned in_sent;
  int unsigned out_hold;
  int unsigned stall;
  int unsigned cycles = 0;
  int          check_errors;
  int          pending_bytes;

  scrp_in_if  in_ch();
  scrp_cfg_if cfg_ch();
  scrp_out_if out_ch();

  serial_command_radio_packetizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  scrp_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_ch      (cfg_ch),
    .out_ch      (out_ch),
    .errors      (check_errors),
    .outstanding (pending_bytes)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_hold     <= 0;
      out_ch.ready <= 1'b0;
    end else if (out_hold != 0) begin
      out_hold <= out_hold - 1;
      out_ch.ready <= (out_hold == 1);
    end else if (out_ch.valid && out_ch.ready) begin
      stall = quiet ? 0 : $urandom_range(0, 7);
      out_ch.ready <= (stall == 0);
      out_hold <= stall;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send(input logic op, input logic [7:0] b, input logic ok);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.data_byte <= b;
    in_ch.radio_ok  <= ok;
    do @(posedge clk); while (!in_ch.ready);
    in_sent++;
  endtask

  task automatic serial_byte(input logic [7:0] b);
    send(OP_SERIAL, b, 1'($urandom_range(0, 1)));
  endtask

  task automatic radio_status(input logic ok);
    send(OP_STATUS, 8'($urandom_range(0, 255)), ok);
  endtask

  // hold the input until every expected byte is out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_TRANSMIT_CODE)
      tx_code = val;
    else
      echo_code = val;
  endtask

  task automatic run_transmit(input int len, input int fail_pct);
    int   fill;
    logic up;
    logic first;
    logic close;
    logic ok;
    serial_byte(tx_code);
    serial_byte(len[7:0]);
    fill  = 0;
    up    = 1'b1;
    first = 1'b1;
    for (int i = 0; i < len; i++) begin
      serial_byte(8'($urandom_range(0, 255)));
      if (up) begin
        if (fill == 0) begin
          fill  = first ? 2 : 1;
          first = 1'b0;
        end
        fill++;
        if (len <= PAYLOAD_BYTES - 2)
          close = (i == len - 1);
        else
          close = (fill == PAYLOAD_BYTES) || (i == len - 1);
        if (close) begin
          fill = 0;
          if ($urandom_range(0, 6) == 0)
            serial_byte(8'($urandom_range(0, 255)));
          ok = ($urandom_range(0, 99) >= fail_pct);
          radio_status(ok);
          up = ok;
        end
      end
    end
  endtask

  task automatic run_serial_cmd(input logic [7:0] code, input int len);
    serial_byte(code);
    serial_byte(len[7:0]);
    repeat (len) serial_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic int rand_len();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(1, 12);
    return $urandom_range(25, 36);
  endfunction

  task automatic random_command();
    int unsigned pick;
    logic [7:0]  code;
    quiet = ($urandom_range(0, 3) == 0);
    pick  = $urandom_range(0, 99);
    if (pick < 55) begin
      run_transmit(rand_len(), $urandom_range(0, 30));
    end else if (pick < 75) begin
      if (echo_code == tx_code)
        run_transmit(rand_len(), $urandom_range(0, 30));
      else
        run_serial_cmd(echo_code, rand_len());
    end else if (pick < 85) begin
      do code = 8'($urandom_range(0, 255)); while (code == tx_code || code == echo_code);
      run_serial_cmd(code, rand_len());
    end else if (pick < 92) begin
      run_transmit(0, 0);
    end else if (pick < 97) begin
      radio_status(1'($urandom_range(0, 1)));
    end else begin
      drain();
    end
  endtask

  initial begin
    int unsigned target;
    clk              = 1'b0;
    rst_n            = 1'b0;
    quiet            = 1'b0;
    tx_code          = 8'd0;
    echo_code        = 8'd1;
    in_sent          = 0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_SERIAL;
    in_ch.data_byte  = 8'd0;
    in_ch.radio_ok   = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_TRANSMIT_CODE;
    cfg_ch.data      = 8'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    radio_status(1'b1);
    run_transmit(0, 0);
    serial_byte(tx_code);
    serial_byte(8'd1);
    serial_byte(8'h80);
    serial_byte(8'h11);
    radio_status(1'b1);
    run_transmit(2, 100);
    serial_byte(echo_code);
    serial_byte(8'd2);
    serial_byte(8'h00);
    serial_byte(8'hFF);
    serial_byte(8'hA5);
    serial_byte(8'd1);
    serial_byte(8'h3C);
    serial_byte(echo_code);
    serial_byte(8'd0);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          set_reg(REG_TRANSMIT_CODE, 8'hFF);
          set_reg(REG_ECHO_CODE, 8'h00);
        end
        1: begin
          set_reg(REG_TRANSMIT_CODE, 8'h5A);
          set_reg(REG_ECHO_CODE, 8'h5A);
        end
        2: begin
          set_reg(REG_TRANSMIT_CODE, 8'($urandom_range(0, 255)));
          set_reg(REG_ECHO_CODE, 8'($urandom_range(0, 255)));
        end
        default: begin
          set_reg(REG_TRANSMIT_CODE, 8'h00);
          set_reg(REG_ECHO_CODE, 8'hFF);
        end
      endcase
      if (p == 0) begin
        quiet = 1'b0;
        run_transmit(31, 15);
        run_transmit(40, 100);
        run_serial_cmd(8'h77, 3);
      end
      target = in_sent + 10;
      while (in_sent < target) random_command();
      drain();
    end

    if (check_errors == 0 && pending_bytes == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
